// ===== rtl/core/wide_unsigned_alu_320_unit_macros.svh =====
// assertion macros for the wide unsigned alu
`ifndef WIDE_UNSIGNED_ALU_320_UNIT_MACROS_SVH
`define WIDE_UNSIGNED_ALU_320_UNIT_MACROS_SVH
`ifndef SYNTH
`define WUA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("wua check failed");
`define WUA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("wua reset check failed");
`else
`define WUA_ASSERT(lbl, prop)
`define WUA_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/core/wua_pkg.sv =====
// shared constants, operation codes and control struct of the wide unsigned alu
package wua_pkg;
  localparam int LIMB_W         = 64;
  localparam int LIMB_COUNT_DEF = 5;
  localparam int OP_W           = 4;
  localparam int SHIFT_W        = 9;
  localparam int ORD_W          = 2;

  localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
  localparam logic [OP_W-1:0] OP_SHR  = 4'd4;
  localparam logic [OP_W-1:0] OP_SHL  = 4'd5;
  localparam logic [OP_W-1:0] OP_CMP  = 4'd6;
  localparam logic [OP_W-1:0] OP_EQ   = 4'd7;
  localparam logic [OP_W-1:0] OP_ZERO = 4'd8;

  localparam logic [ORD_W-1:0] ORD_EQ   = 2'b00;
  localparam logic [ORD_W-1:0] ORD_GT   = 2'b01;
  localparam logic [ORD_W-1:0] ORD_LT   = 2'b11;

  // control and status that travel with each item down the chain
  typedef struct packed {
    logic             valid;
    logic [OP_W-1:0]  op;
    logic             flag;
    logic [ORD_W-1:0] ord;
  } ctl_t;
endpackage

// ===== rtl/core/wua_limb_cell.sv =====
// one limb position: add, sub, scalar multiply, compare, equal and zero test
module wua_limb_cell #(
  parameter int LIMB_COUNT = wua_pkg::LIMB_COUNT_DEF,
  parameter int IDX        = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  wua_pkg::ctl_t                         ctl_in,
  input  logic [LIMB_COUNT*wua_pkg::LIMB_W-1:0] a_in,
  input  logic [LIMB_COUNT*wua_pkg::LIMB_W-1:0] b_in,
  input  logic [LIMB_COUNT*wua_pkg::LIMB_W-1:0] res_in,
  input  logic [wua_pkg::LIMB_W-1:0]            carry_in,
  // partial products of this limb: p00, p01, p10, p11 from the lowest bit up
  input  logic [4*wua_pkg::LIMB_W-1:0]          pp_in,
  output wua_pkg::ctl_t                         ctl_out,
  output logic [LIMB_COUNT*wua_pkg::LIMB_W-1:0] a_out,
  output logic [LIMB_COUNT*wua_pkg::LIMB_W-1:0] b_out,
  output logic [LIMB_COUNT*wua_pkg::LIMB_W-1:0] res_out,
  output logic [wua_pkg::LIMB_W-1:0]            carry_out,
  // partial products of the next limb up, zero for the top limb
  output logic [4*wua_pkg::LIMB_W-1:0]          pp_out
);
  import wua_pkg::*;

  localparam int W    = LIMB_COUNT * LIMB_W;
  localparam int HALF = LIMB_W / 2;

  logic [LIMB_W-1:0]   a_l;
  logic [LIMB_W-1:0]   b_l;
  logic [LIMB_W:0]     sum;
  logic [LIMB_W:0]     dif;
  logic [LIMB_W-1:0]   p00;
  logic [LIMB_W-1:0]   p01;
  logic [LIMB_W-1:0]   p10;
  logic [LIMB_W-1:0]   p11;
  logic [LIMB_W-1:0]   mid;
  logic [LIMB_W-1:0]   mul_lo;
  logic [LIMB_W-1:0]   mul_hi;
  logic [4*LIMB_W-1:0] pp_next;
  ctl_t                ctl_next;
  logic [W-1:0]        res_next;
  logic [LIMB_W-1:0]   carry_next;

  assign a_l  = a_in[IDX*LIMB_W +: LIMB_W];
  assign b_l  = b_in[IDX*LIMB_W +: LIMB_W];
  assign sum  = {1'b0, a_l} + {1'b0, b_l} + {{LIMB_W{1'b0}}, carry_in[0]};
  assign dif  = {1'b0, a_l} - {1'b0, b_l} - {{LIMB_W{1'b0}}, carry_in[0]};

  // combine the four half-width products of this limb into a 128-bit product
  assign {p11, p10, p01, p00} = pp_in;
  assign mid    = {{HALF{1'b0}}, p00[LIMB_W-1:HALF]} + {{HALF{1'b0}}, p01[HALF-1:0]}
                + {{HALF{1'b0}}, p10[HALF-1:0]};
  assign mul_lo = {mid[HALF-1:0], p00[HALF-1:0]};
  assign mul_hi = p11 + {{HALF{1'b0}}, p01[LIMB_W-1:HALF]}
                + {{HALF{1'b0}}, p10[LIMB_W-1:HALF]} + {{HALF{1'b0}}, mid[LIMB_W-1:HALF]};

  // half-width products for the next limb, handed on with the item
  if (IDX + 1 < LIMB_COUNT) begin : g_next
    logic [LIMB_W-1:0] a_nx;
    logic [LIMB_W-1:0] b_0;
    assign a_nx    = a_in[(IDX+1)*LIMB_W +: LIMB_W];
    assign b_0     = b_in[LIMB_W-1:0];
    assign pp_next = {{{HALF{1'b0}}, a_nx[LIMB_W-1:HALF]} * {{HALF{1'b0}}, b_0[LIMB_W-1:HALF]},
                      {{HALF{1'b0}}, a_nx[LIMB_W-1:HALF]} * {{HALF{1'b0}}, b_0[HALF-1:0]},
                      {{HALF{1'b0}}, a_nx[HALF-1:0]} * {{HALF{1'b0}}, b_0[LIMB_W-1:HALF]},
                      {{HALF{1'b0}}, a_nx[HALF-1:0]} * {{HALF{1'b0}}, b_0[HALF-1:0]}};
  end else begin : g_top
    assign pp_next = '0;
  end

  // per-limb update of the running result
  always_comb begin
    ctl_next   = ctl_in;
    res_next   = res_in;
    carry_next = carry_in;
    unique case (ctl_in.op)
      OP_ADD: begin
        res_next[IDX*LIMB_W +: LIMB_W] = sum[LIMB_W-1:0];
        carry_next = {{(LIMB_W-1){1'b0}}, sum[LIMB_W]};
      end
      OP_SUB: begin
        res_next[IDX*LIMB_W +: LIMB_W] = dif[LIMB_W-1:0];
        carry_next = {{(LIMB_W-1){1'b0}}, dif[LIMB_W]};
      end
      OP_MUL: begin
        res_next[IDX*LIMB_W +: LIMB_W] = mul_lo + carry_in;
        carry_next = mul_hi
                   + {{(LIMB_W-1){1'b0}}, (mul_lo + carry_in) < carry_in};
      end
      OP_CMP: begin
        // higher limbs come later and override
        if (a_l > b_l) begin
          ctl_next.ord = ORD_GT;
        end else if (a_l < b_l) begin
          ctl_next.ord = ORD_LT;
        end
      end
      OP_EQ: begin
        if (a_l != b_l) begin
          ctl_next.flag = 1'b0;
        end
      end
      OP_ZERO: begin
        if (a_l != '0) begin
          ctl_next.flag = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.op   <= ctl_next.op;
      ctl_out.flag <= ctl_next.flag;
      ctl_out.ord  <= ctl_next.ord;
      a_out        <= a_in;
      b_out        <= b_in;
      res_out      <= res_next;
      carry_out    <= carry_next;
      pp_out       <= pp_next;
    end
  end
endmodule

// ===== rtl/core/wua_div_cell.sv =====
// one restoring division step: shifts one dividend bit into the remainder
module wua_div_cell #(
  parameter int LIMB_COUNT = wua_pkg::LIMB_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  wua_pkg::ctl_t                         ctl_in,
  input  logic [LIMB_COUNT*wua_pkg::LIMB_W-1:0] a_in,
  input  logic [wua_pkg::LIMB_W-1:0]            d_in,
  input  logic [wua_pkg::LIMB_W-1:0]            r_in,
  input  logic [LIMB_COUNT*wua_pkg::LIMB_W-1:0] res_in,
  output wua_pkg::ctl_t                         ctl_out,
  output logic [LIMB_COUNT*wua_pkg::LIMB_W-1:0] a_out,
  output logic [wua_pkg::LIMB_W-1:0]            d_out,
  output logic [wua_pkg::LIMB_W-1:0]            r_out,
  output logic [LIMB_COUNT*wua_pkg::LIMB_W-1:0] res_out
);
  import wua_pkg::*;

  localparam int W = LIMB_COUNT * LIMB_W;

  logic [LIMB_W-1:0] r_sh;
  logic              take;
  logic [W-1:0]      a_next;
  logic [LIMB_W-1:0] r_next;

  // a holds the dividend bits still to come above the quotient bits so far
  assign r_sh = {r_in[LIMB_W-2:0], a_in[W-1]};
  assign take = r_in[LIMB_W-1] | (r_sh >= d_in);

  always_comb begin
    a_next = a_in;
    r_next = r_in;
    if (ctl_in.op == OP_DIV) begin
      a_next = {a_in[W-2:0], take};
      r_next = take ? (r_sh - d_in) : r_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.op   <= ctl_in.op;
      ctl_out.flag <= ctl_in.flag;
      ctl_out.ord  <= ctl_in.ord;
      a_out        <= a_next;
      d_out        <= d_in;
      r_out        <= r_next;
      res_out      <= res_in;
    end
  end
endmodule

// ===== rtl/core/wide_unsigned_alu_320_unit.sv =====
// top level of the wide unsigned alu: front stage, limb cells, division cells, output
//
// channel | dir | handshake              | tdata fields (lowest bit up)
// s_axis  | in  | s_tvalid / s_tready    | op, operand_a_limb0..N, operand_b_limb0..N, shift_amount
// m_axis  | out | m_tvalid / m_tready    | result_limb0..N, status_flag, remainder, order
//
// one item per clock while the output is not stalled; each item passes the front stage, the limb cells,
// a one-bit division cell for each quotient bit, and the output register
// rst clears all stage valid bits; no clearing pass
// a stalled output freezes the whole chain; s_tready is low only then
module wide_unsigned_alu_320_unit #(
  parameter int LIMB_COUNT = wua_pkg::LIMB_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // op, operand_a_limb0..N, operand_b_limb0..N, shift_amount, zero pad
  input  logic [((wua_pkg::OP_W + 2*LIMB_COUNT*wua_pkg::LIMB_W + wua_pkg::SHIFT_W + 7)/8)*8-1:0]
               s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // result_limb0..N, status_flag, remainder, order, zero pad
  output logic [((LIMB_COUNT*wua_pkg::LIMB_W + 1 + wua_pkg::LIMB_W + wua_pkg::ORD_W + 7)/8)*8-1:0]
               m_tdata
);
  import wua_pkg::*;

  `include "wide_unsigned_alu_320_unit_macros.svh"

  localparam int W     = LIMB_COUNT * LIMB_W;
  localparam int NDIV  = W;
  localparam int OUT_B = W + 1 + LIMB_W + ORD_W;
  localparam int OUT_W = ((OUT_B + 7) / 8) * 8;
  localparam int HALF  = LIMB_W / 2;

  logic                 en;
  logic [OP_W-1:0]      in_op;
  logic [W-1:0]         in_a;
  logic [W-1:0]         in_b;
  logic [SHIFT_W-1:0]   in_sh;
  logic [W-1:0]         sh_res;
  logic [4*LIMB_W-1:0]  in_pp;

  ctl_t                 lc_ctl   [0:LIMB_COUNT];
  logic [W-1:0]         lc_a     [0:LIMB_COUNT];
  logic [W-1:0]         lc_b     [0:LIMB_COUNT];
  logic [W-1:0]         lc_res   [0:LIMB_COUNT];
  logic [LIMB_W-1:0]    lc_carry [0:LIMB_COUNT];
  logic [4*LIMB_W-1:0]  lc_pp    [0:LIMB_COUNT];

  ctl_t                 dc_ctl   [0:NDIV];
  logic [W-1:0]         dc_a     [0:NDIV];
  logic [LIMB_W-1:0]    dc_d     [0:NDIV];
  logic [LIMB_W-1:0]    dc_r     [0:NDIV];
  logic [W-1:0]         dc_res   [0:NDIV];

  logic [W-1:0]         o_res;
  logic                 o_flag;
  logic [LIMB_W-1:0]    o_rem;
  logic [ORD_W-1:0]     o_ord;
  logic [W-1:0]         res_next;
  logic                 flag_next;
  logic [LIMB_W-1:0]    rem_next;
  logic [ORD_W-1:0]     ord_next;
  ctl_t                 last_ctl;
  logic [LIMB_W-1:0]    last_carry;

  // global advance: the output register is free or being emptied
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign in_op = s_tdata[OP_W-1:0];
  assign in_a  = s_tdata[OP_W +: W];
  assign in_b  = s_tdata[OP_W+W +: W];
  assign in_sh = s_tdata[OP_W+2*W +: SHIFT_W];

  // shifts beyond the width fall out as zero
  always_comb begin
    sh_res = '0;
    if (in_op == OP_SHR) begin
      sh_res = in_a >> in_sh;
    end else if (in_op == OP_SHL) begin
      sh_res = in_a << in_sh;
    end
  end

  // half-width products of limb 0 and the scalar for the first cell
  assign in_pp = {{{HALF{1'b0}}, in_a[LIMB_W-1:HALF]} * {{HALF{1'b0}}, in_b[LIMB_W-1:HALF]},
                  {{HALF{1'b0}}, in_a[LIMB_W-1:HALF]} * {{HALF{1'b0}}, in_b[HALF-1:0]},
                  {{HALF{1'b0}}, in_a[HALF-1:0]} * {{HALF{1'b0}}, in_b[LIMB_W-1:HALF]},
                  {{HALF{1'b0}}, in_a[HALF-1:0]} * {{HALF{1'b0}}, in_b[HALF-1:0]}};

  // front stage
  always_ff @(posedge clk) begin
    if (rst) begin
      lc_ctl[0].valid <= 1'b0;
    end else if (en) begin
      lc_ctl[0].valid <= s_tvalid;
    end
    if (en) begin
      lc_ctl[0].op   <= in_op;
      lc_ctl[0].flag <= (in_op == OP_EQ) || (in_op == OP_ZERO);
      lc_ctl[0].ord  <= ORD_EQ;
      lc_a[0]        <= in_a;
      lc_b[0]        <= in_b;
      lc_res[0]      <= sh_res;
      lc_carry[0]    <= '0;
      lc_pp[0]       <= in_pp;
    end
  end

  // limb cells, least significant first
  for (genvar i = 0; i < LIMB_COUNT; i++) begin : g_limb
    wua_limb_cell #(.LIMB_COUNT(LIMB_COUNT), .IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .ctl_in    (lc_ctl[i]),
      .a_in      (lc_a[i]),
      .b_in      (lc_b[i]),
      .res_in    (lc_res[i]),
      .carry_in  (lc_carry[i]),
      .pp_in     (lc_pp[i]),
      .ctl_out   (lc_ctl[i+1]),
      .a_out     (lc_a[i+1]),
      .b_out     (lc_b[i+1]),
      .res_out   (lc_res[i+1]),
      .carry_out (lc_carry[i+1]),
      .pp_out    (lc_pp[i+1])
    );
  end

  // add/sub/mul carry is final after the top limb; fold it into the flag
  always_comb begin
    last_ctl = lc_ctl[LIMB_COUNT];
    if (lc_ctl[LIMB_COUNT].op == OP_ADD || lc_ctl[LIMB_COUNT].op == OP_SUB) begin
      last_ctl.flag = lc_carry[LIMB_COUNT][0];
    end else if (lc_ctl[LIMB_COUNT].op == OP_MUL) begin
      last_ctl.flag = (lc_carry[LIMB_COUNT] != '0);
    end
  end
  assign last_carry = lc_carry[LIMB_COUNT];

  assign dc_ctl[0] = last_ctl;
  assign dc_a[0]   = lc_a[LIMB_COUNT];
  assign dc_d[0]   = lc_b[LIMB_COUNT][LIMB_W-1:0];
  assign dc_r[0]   = '0;
  assign dc_res[0] = lc_res[LIMB_COUNT];

  // division cells, one quotient bit each, top bit first
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    wua_div_cell #(.LIMB_COUNT(LIMB_COUNT)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (dc_ctl[k]),
      .a_in    (dc_a[k]),
      .d_in    (dc_d[k]),
      .r_in    (dc_r[k]),
      .res_in  (dc_res[k]),
      .ctl_out (dc_ctl[k+1]),
      .a_out   (dc_a[k+1]),
      .d_out   (dc_d[k+1]),
      .r_out   (dc_r[k+1]),
      .res_out (dc_res[k+1])
    );
  end

  // final selection, divide by zero gives zeros and the flag
  always_comb begin
    res_next  = dc_res[NDIV];
    flag_next = dc_ctl[NDIV].flag;
    rem_next  = '0;
    ord_next  = dc_ctl[NDIV].ord;
    if (dc_ctl[NDIV].op == OP_DIV) begin
      if (dc_d[NDIV] == '0) begin
        res_next  = '0;
        flag_next = 1'b1;
      end else begin
        res_next  = dc_a[NDIV];
        flag_next = 1'b0;
        rem_next  = dc_r[NDIV];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dc_ctl[NDIV].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_res  <= res_next;
      o_flag <= flag_next;
      o_rem  <= rem_next;
      o_ord  <= ord_next;
    end
  end

  assign m_tdata = {{(OUT_W-OUT_B){1'b0}}, o_ord, o_rem, o_flag, o_res};

  // checks
  `WUA_ASSERT_RST(a_rst_empty, rst |=> !m_tvalid)
  `WUA_ASSERT(a_ready_rule, s_tready == (!m_tvalid || m_tready))
  `WUA_ASSERT(a_ord_excl, (m_tvalid && o_ord != ORD_EQ) |-> (!o_flag && o_rem == '0 && o_res == '0))
  `WUA_ASSERT(a_carry_unused, (last_ctl.valid && last_ctl.op == OP_CMP) |-> (last_carry == '0))
  `WUA_ASSERT(a_pp_top, lc_ctl[LIMB_COUNT].valid |-> (lc_pp[LIMB_COUNT] == '0))
endmodule
